// ----- rtl/core/swmq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window minimum package
// Command codes, default window depth and the data type that moves between
// neighboring cells of the window and candidate chains.
// ----------------------------------------------------------------------------
package swmq_pkg;

  // Command codes.
  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_EJECT = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Default number of entries the window holds.
  localparam int DEFAULT_WINDOW_DEPTH = 64;

  // Contents of one cell: a flag, the entry value and the entry key.
  typedef struct packed {
    logic               flag;
    logic signed [31:0] value;
    logic        [31:0] key;
  } cell_data_t;

  // Per-beat controls broadcast to every cell.
  typedef struct packed {
    logic               push;
    logic               eject;
    logic               clear;
    logic signed [31:0] value;
    logic        [31:0] key;
  } cell_ctrl_t;

endpackage

// ----- rtl/core/sliding_window_min_queue_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window minimum core
// First-in first-out window of (value, key) pairs that reports the window
// minimum, its earliest key, the oldest and newest keys and the fill count.
// ----------------------------------------------------------------------------
// A beat accepted at one clock edge has its result on the ports, with done
// high, for the following cycle, and busy is never raised, so a new command
// may be issued every cycle. This rests on the two rows of cells, which all
// compare against a pushed value in parallel and all shift one place on an
// eject together. The
// receiver cannot stall and must take each result in its done cycle. A push
// on a full window or an eject on an empty one leaves the state unchanged
// and reports op_error.
module sliding_window_min_queue_core #(
  parameter int WINDOW_DEPTH = swmq_pkg::DEFAULT_WINDOW_DEPTH,
  parameter int CW           = $clog2(WINDOW_DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         command,
  input  logic signed [31:0] value,
  input  logic [31:0]        entry_key,
  output logic               done,
  output logic signed [31:0] min_value,
  output logic [31:0]        min_key,
  output logic [31:0]        oldest_key,
  output logic [31:0]        newest_key,
  output logic [CW-1:0]      entry_count,
  output logic               is_empty,
  output logic               op_error
);
  import swmq_pkg::*;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [31:0]   newest;
  logic [31:0]   newest_next;
  logic          err;
  logic          err_next;
  logic          full;
  logic          empty;
  cell_ctrl_t    ctrl;
  logic          cand_shift;
  cell_data_t    win  [WINDOW_DEPTH+1];
  cell_data_t    cand [WINDOW_DEPTH+1];
  logic          keep [WINDOW_DEPTH+1];

  assign busy  = 1'b0;
  assign full  = count == CW'(WINDOW_DEPTH);
  assign empty = count == '0;

  // Decode the accepted beat into cell controls.
  always_comb begin
    ctrl.push  = 1'b0;
    ctrl.eject = 1'b0;
    ctrl.clear = 1'b0;
    ctrl.value = value;
    ctrl.key   = entry_key;
    err_next   = 1'b0;
    if (start) begin
      case (command)
        CMD_PUSH: begin
          ctrl.push = ~full;
          err_next  = full;
        end
        CMD_EJECT: begin
          ctrl.eject = ~empty;
          err_next   = empty;
        end
        CMD_CLEAR: begin
          ctrl.clear = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // The candidate front leaves with the oldest entry when it is that entry.
  assign cand_shift = ctrl.eject & win[0].flag;

  // Fill count and newest key.
  always_comb begin
    count_next  = count;
    newest_next = newest;
    if (ctrl.clear) begin
      count_next = '0;
    end else if (ctrl.push) begin
      count_next  = count + 1'b1;
      newest_next = entry_key;
    end else if (ctrl.eject) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
      err   <= 1'b0;
    end else begin
      count <= count_next;
      done  <= start;
      err   <= err_next;
    end
    newest <= newest_next;
  end

  // Ends of the two chains.
  assign win[WINDOW_DEPTH]  = '0;
  assign cand[WINDOW_DEPTH] = '0;
  assign keep[0]            = 1'b1;

  // Rows of window cells and candidate cells.
  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    swmq_win_cell u_win (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .write_here (count == CW'(i)),
      .from_next  (win[i+1]),
      .data       (win[i])
    );

    swmq_cand_cell u_cand (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .shift     (cand_shift),
      .prev_keep (keep[i]),
      .from_next (cand[i+1]),
      .data      (cand[i]),
      .keep      (keep[i+1])
    );
  end

  // Front cells give min and oldest key, a register newest; zero if empty.
  assign entry_count = count;
  assign is_empty    = empty;
  assign op_error    = err;
  assign min_value   = empty ? '0 : cand[0].value;
  assign min_key     = empty ? '0 : cand[0].key;
  assign oldest_key  = empty ? '0 : win[0].key;
  assign newest_key  = empty ? '0 : newest;

endmodule

// ----- rtl/core/swmq_win_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window cell
// Holds one window entry in age order. An eject shifts every entry one cell
// toward the front; a push writes the cell that sits at the fill count. The
// flag marks entries that are still on the candidate queue.
// ----------------------------------------------------------------------------
module swmq_win_cell (
  input  logic                clk,
  input  logic                rst,
  input  swmq_pkg::cell_ctrl_t ctrl,
  input  logic                write_here,
  input  swmq_pkg::cell_data_t from_next,
  output swmq_pkg::cell_data_t data
);
  import swmq_pkg::*;

  cell_data_t data_next;
  logic       greater;

  // A held entry drops off the candidate queue when a smaller value arrives.
  assign greater = data.value > ctrl.value;

  // Next contents of this cell.
  always_comb begin
    data_next = data;
    if (ctrl.eject) begin
      data_next = from_next;
    end else if (ctrl.push) begin
      if (write_here) begin
        data_next.flag  = 1'b1;
        data_next.value = ctrl.value;
        data_next.key   = ctrl.key;
      end else begin
        data_next.flag = data.flag & ~greater;
      end
    end
  end

  // Cell storage; the fill count decides which cells mean anything.
  always_ff @(posedge clk) begin
    if (rst) begin
      data.flag <= 1'b0;
    end else begin
      data.flag <= data_next.flag;
    end
    data.value <= data_next.value;
    data.key   <= data_next.key;
  end

endmodule

// ----- rtl/core/swmq_cand_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Candidate cell
// One place of the monotone candidate queue, front at the first cell. On a
// push every cell compares its value against the new one at once; cells
// holding a greater value empty, and the first emptied or empty cell after
// the kept prefix takes the new entry.
// ----------------------------------------------------------------------------
module swmq_cand_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  swmq_pkg::cell_ctrl_t ctrl,
  input  logic                 shift,
  input  logic                 prev_keep,
  input  swmq_pkg::cell_data_t from_next,
  output swmq_pkg::cell_data_t data,
  output logic                 keep
);
  import swmq_pkg::*;

  cell_data_t data_next;

  // The cell survives a push when it is valid and not greater than the new value.
  assign keep = data.flag & ~(data.value > ctrl.value);

  // Next contents of this cell.
  always_comb begin
    data_next = data;
    if (ctrl.clear) begin
      data_next.flag = 1'b0;
    end else if (shift) begin
      data_next = from_next;
    end else if (ctrl.push) begin
      if (!keep) begin
        data_next.flag  = prev_keep;
        data_next.value = ctrl.value;
        data_next.key   = ctrl.key;
      end
    end
  end

  // Cell storage; the flag is the valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      data.flag <= 1'b0;
    end else begin
      data.flag <= data_next.flag;
    end
    data.value <= data_next.value;
    data.key   <= data_next.key;
  end

endmodule
